/* rtl/rcwcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rcwcp_pkg;

  localparam logic [31:0] DIST_FLOOR = 32'd58982;
  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_PLAYER_X = 2'd0,
    CFG_PLAYER_Y = 2'd1,
    CFG_TEX_WIDTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TEX_EAST = 2'd0,
    TEX_WEST = 2'd1,
    TEX_NORTH = 2'd2,
    TEX_SOUTH = 2'd3
  } tex_sel_e;

  typedef struct packed {
    logic [9:0] column_index;
    logic hit_side;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic step_x_back;
    logic step_y_back;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] column_out;
    logic [31:0] wall_distance;
    logic [8:0] wall_start_row;
    logic [9:0] wall_end_row;
    logic [9:0] row_span;
    logic [11:0] texture_column;
    logic [1:0] texture_select;
  } out_beat_t;

endpackage
`default_nettype wire

/* rtl/raycast_wall_column_projection_top.sv */
// Channel   Handshake                  Payload
// config    cfg_we_i, cfg_idx_i        cfg_data_i
// column    start_i while busy_o low   in_beat_i
// result    done_o, one cycle          out_beat_o
// One column beat may enter every cycle; busy_o is always low.
// The result strobe follows the entry stage, the distance divider, the clamp
// stage, the texture stages, the height divider and the output stage; the two
// bit-per-stage dividers run in series (49 and 48 stages).
// Reset clears the valid bits and sets the registers to their reset values.
// The receiver cannot stall; results leave in input order.
`timescale 1ns / 1ps
`default_nettype none
module raycast_wall_column_projection_top
  import rcwcp_pkg::*;
#(
  parameter int unsigned SCREEN_HEIGHT = 512
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_we_i,
  input wire logic [1:0] cfg_idx_i,
  input wire logic [23:0] cfg_data_i,
  input wire logic start_i,
  output logic busy_o,
  input wire in_beat_t in_beat_i,
  output logic done_o,
  output out_beat_t out_beat_o
);

  localparam logic [31:0] HALF_H = 32'(SCREEN_HEIGHT / 2);
  localparam logic [31:0] SCR_H = 32'(SCREEN_HEIGHT);
  localparam logic [47:0] LEN_NUM = 48'(SCREEN_HEIGHT) << 16;

  logic [23:0] player_x_q, player_y_q;
  logic [12:0] tex_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      tex_w_q <= 13'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLAYER_X: player_x_q <= cfg_data_i;
        CFG_PLAYER_Y: player_y_q <= cfg_data_i;
        CFG_TEX_WIDTH: tex_w_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  logic acc;
  assign acc = start_i;

  // Stage 1: numerator, magnitudes.
  logic v1_q;
  logic [32:0] nmag1_q;
  logic [31:0] dmag1_q;
  logic neg1_q, dz1_q;
  logic [9:0] col1_q;
  logic side1_q;
  logic [1:0] sel1_q;
  logic signed [31:0] odir1_q;

  logic signed [34:0] num_c;
  logic signed [31:0] dir_c;
  logic [1:0] sel_c;
  always_comb begin
    if (!in_beat_i.hit_side) begin
      num_c = $signed({3'b0, in_beat_i.cell_x, 16'b0}) - $signed({11'b0, player_x_q})
            + $signed({18'b0, in_beat_i.step_x_back, 16'b0});
      dir_c = in_beat_i.ray_dir_x;
      sel_c = in_beat_i.ray_dir_x[31] ? TEX_EAST : TEX_WEST;
    end else begin
      num_c = $signed({3'b0, in_beat_i.cell_y, 16'b0}) - $signed({11'b0, player_y_q})
            + $signed({18'b0, in_beat_i.step_y_back, 16'b0});
      dir_c = in_beat_i.ray_dir_y;
      sel_c = (in_beat_i.ray_dir_y > 0) ? TEX_NORTH : TEX_SOUTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    nmag1_q <= num_c[34] ? 33'(-num_c) : num_c[32:0];
    dmag1_q <= dir_c[31] ? -dir_c : dir_c;
    neg1_q <= (num_c[34] != dir_c[31]);
    dz1_q <= (dir_c == 0);
    col1_q <= in_beat_i.column_index;
    side1_q <= in_beat_i.hit_side;
    sel1_q <= sel_c;
    odir1_q <= in_beat_i.hit_side ? in_beat_i.ray_dir_x : in_beat_i.ray_dir_y;
  end

  // Distance divider; tag carries sideband.
  localparam int unsigned TW1 = 10 + 1 + 2 + 32 + 1 + 1;
  logic dv_o;
  logic [48:0] dq;
  logic [TW1-1:0] dtag;
  rcwcp_div #(.NW(49), .DW(32), .TW(TW1)) u_div_dist (
    .clk_i, .rst_ni, .valid_i(v1_q),
    .num_i({nmag1_q, 16'b0}), .den_i(dmag1_q | {31'b0, dz1_q}),
    .tag_i({col1_q, side1_q, sel1_q, odir1_q, neg1_q, dz1_q}),
    .valid_o(dv_o), .quo_o(dq), .tag_o(dtag)
  );

  // Stage: clamp distance.
  logic v2_q;
  logic [31:0] dist2_q;
  logic [9:0] col2_q;
  logic side2_q;
  logic [1:0] sel2_q;
  logic signed [31:0] odir2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= dv_o;
  end
  always_ff @(posedge clk_i) begin
    if (dtag[0]) dist2_q <= DIST_MAX;
    else if (dtag[1] || dq <= 49'(DIST_FLOOR)) dist2_q <= DIST_FLOOR;
    else if (dq > 49'(DIST_MAX)) dist2_q <= DIST_MAX;
    else dist2_q <= dq[31:0];
    {col2_q, side2_q, sel2_q, odir2_q} <= dtag[TW1-1:2];
  end

  // Height divider after the texture path (distance and texture column via tag).
  localparam int unsigned TW2 = 10 + 2 + 32 + 12;
  logic lv_o;
  logic [47:0] lq;
  logic [TW2-1:0] ltag;

  // Texture path: product, fraction, scale; distance, column and select ride along.
  // Only bits 16 to 31 of the product matter, so the low word is enough.
  logic v3_q, v4_q, v5_q;
  logic [31:0] prod3_q;
  logic [15:0] frac4_q;
  logic [28:0] tx5_q;
  logic [31:0] dist3_q, dist4_q, dist5_q;
  logic [9:0] col3_q, col4_q, col5_q;
  logic [1:0] sel3_q, sel4_q, sel5_q;
  logic side3_q;
  logic [11:0] texc5_c;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end
  always_ff @(posedge clk_i) begin
    prod3_q <= dist2_q * $unsigned(odir2_q);
    dist3_q <= dist2_q; col3_q <= col2_q; sel3_q <= sel2_q; side3_q <= side2_q;
    frac4_q <= prod3_q[31:16] + (side3_q ? player_x_q[15:0] : player_y_q[15:0]);
    dist4_q <= dist3_q; col4_q <= col3_q; sel4_q <= sel3_q;
    tx5_q <= frac4_q * tex_w_q;
    dist5_q <= dist4_q; col5_q <= col4_q; sel5_q <= sel4_q;
  end
  logic [12:0] tx_c;
  always_comb begin
    tx_c = tx5_q[28:16];
    if (tex_w_q == 0) tx_c = '0;
    else if (tx_c >= tex_w_q) tx_c = tex_w_q - 13'd1;
    if (tx_c > 13'd4095) tx_c = 13'd4095;
  end
  assign texc5_c = tx_c[11:0];

  rcwcp_div #(.NW(48), .DW(32), .TW(TW2)) u_div_len (
    .clk_i, .rst_ni, .valid_i(v5_q),
    .num_i(LEN_NUM), .den_i(dist5_q),
    .tag_i({col5_q, sel5_q, dist5_q, texc5_c}),
    .valid_o(lv_o), .quo_o(lq), .tag_o(ltag)
  );

  // Rows.
  logic [47:0] half_c;
  logic [31:0] start_c, end_c;
  always_comb begin
    half_c = lq >> 1;
    start_c = (half_c >= 48'(HALF_H)) ? '0 : HALF_H - half_c[31:0];
    if (half_c + 48'(HALF_H) > 48'(SCR_H)) end_c = SCR_H - 32'd1;
    else end_c = half_c[31:0] + HALF_H;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= lv_o;
  end
  always_ff @(posedge clk_i) begin
    out_beat_o.column_out <= ltag[TW2-1 -: 10];
    out_beat_o.texture_select <= ltag[45:44];
    out_beat_o.wall_distance <= ltag[43:12];
    out_beat_o.texture_column <= ltag[11:0];
    out_beat_o.wall_start_row <= start_c[8:0];
    out_beat_o.wall_end_row <= end_c[9:0];
    out_beat_o.row_span <= 10'(end_c - start_c);
  end

`ifndef SYNTHESIS
  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_beat_o.wall_distance >= DIST_FLOOR)
    else $error("distance below floor");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_beat_o.wall_end_row >= 10'(out_beat_o.wall_start_row))
    else $error("rows inverted");
`endif

endmodule
`default_nettype wire

/* rtl/rcwcp_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rcwcp_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic valid_i,
  input wire logic [NW-1:0] num_i,
  input wire logic [DW-1:0] den_i,
  input wire logic [TW-1:0] tag_i,
  output logic valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  // One quotient bit per stage: remainder, shifting dividend, divisor.
  logic vld_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] tag_in;
    logic [DW:0] trial;
    logic [DW+1:0] diff;
    if (s == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_link
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end
    assign trial = {rem_in, num_in[NW-1]};
    assign diff = {1'b0, trial} - {2'b0, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (!diff[DW+1]) begin
        rem_q[s] <= diff[DW-1:0];
        num_q[s] <= {num_in[NW-2:0], 1'b1};
      end else begin
        rem_q[s] <= trial[DW-1:0];
        num_q[s] <= {num_in[NW-2:0], 1'b0};
      end
      den_q[s] <= den_in;
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o = num_q[NW-1];
  assign tag_o = tag_q[NW-1];

endmodule
`default_nettype wire

/* test/wall_projection_checker.sv */
`timescale 1ns / 1ps
module wall_projection_checker
  import rcwcp_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_we_i,
  input wire logic [1:0] cfg_idx_i,
  input wire logic [23:0] cfg_data_i,
  input wire logic start_i,
  input wire logic busy_i,
  input wire in_beat_t in_beat_i,
  input wire logic done_i,
  input wire out_beat_t out_beat_i,
  output int fail_count_o,
  output int pending_o,
  output int seen_o
);
  localparam longint unsigned HEIGHT = 512;

  logic [23:0] pos_x;
  logic [23:0] pos_y;
  logic [12:0] tex_w;
  out_beat_t expected_columns[$];

  function automatic out_beat_t project_column(in_beat_t b);
    out_beat_t r;
    longint num;
    longint dir;
    longint unsigned nmag;
    longint unsigned dmag;
    longint unsigned q;
    longint unsigned len;
    longint unsigned prod;
    longint unsigned frac;
    longint unsigned texc;
    longint half;
    longint first;
    longint last;
    logic [31:0] dist_v;
    if (!b.hit_side) begin
      num = longint'(b.cell_x) * 65536 - longint'(pos_x) + (b.step_x_back ? 65536 : 0);
      dir = longint'(b.ray_dir_x);
    end else begin
      num = longint'(b.cell_y) * 65536 - longint'(pos_y) + (b.step_y_back ? 65536 : 0);
      dir = longint'(b.ray_dir_y);
    end
    if (dir == 0) begin
      dist_v = DIST_MAX;
    end else begin
      nmag = (num < 0) ? -num : num;
      dmag = (dir < 0) ? -dir : dir;
      q = (nmag << 16) / dmag;
      if (((num < 0) != (dir < 0)) || q <= DIST_FLOOR) dist_v = DIST_FLOOR;
      else if (q > 64'hFFFF_FFFF) dist_v = DIST_MAX;
      else dist_v = q[31:0];
    end
    len = (HEIGHT << 16) / longint'(dist_v);
    half = len / 2;
    first = HEIGHT / 2 - half;
    if (first < 0) first = 0;
    last = half + HEIGHT / 2;
    if (last > HEIGHT) last = HEIGHT - 1;
    if (!b.hit_side) prod = longint'(dist_v) * longint'(b.ray_dir_y);
    else prod = longint'(dist_v) * longint'(b.ray_dir_x);
    frac = ((prod >> 16) + (b.hit_side ? pos_x : pos_y)) & 64'hFFFF;
    if (tex_w == 0) begin
      texc = 0;
    end else begin
      texc = (frac * tex_w) >> 16;
      if (texc >= tex_w) texc = tex_w - 1;
      if (texc > 4095) texc = 4095;
    end
    r.column_out = b.column_index;
    r.wall_distance = dist_v;
    r.wall_start_row = first[8:0];
    r.wall_end_row = last[9:0];
    r.row_span = 10'(last - first);
    r.texture_column = texc[11:0];
    if (!b.hit_side) r.texture_select = (b.ray_dir_x < 0) ? TEX_EAST : TEX_WEST;
    else r.texture_select = (b.ray_dir_y > 0) ? TEX_NORTH : TEX_SOUTH;
    return r;
  endfunction

  assign pending_o = expected_columns.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      pos_x <= '0;
      pos_y <= '0;
      tex_w <= 13'd64;
      fail_count_o <= 0;
      seen_o <= 0;
    end else begin
      if (done_i) begin
        seen_o <= seen_o + 1;
        if (expected_columns.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_columns.pop_front();
          if (e !== out_beat_i) fail_count_o <= fail_count_o + 1;
          if (e.column_out !== out_beat_i.column_out)
            $error("column_out exp %0d got %0d", e.column_out, out_beat_i.column_out);
          if (e.wall_distance !== out_beat_i.wall_distance)
            $error("wall_distance exp %h got %h", e.wall_distance, out_beat_i.wall_distance);
          if (e.wall_start_row !== out_beat_i.wall_start_row)
            $error("wall_start_row exp %0d got %0d", e.wall_start_row,
                   out_beat_i.wall_start_row);
          if (e.wall_end_row !== out_beat_i.wall_end_row)
            $error("wall_end_row exp %0d got %0d", e.wall_end_row, out_beat_i.wall_end_row);
          if (e.row_span !== out_beat_i.row_span)
            $error("row_span exp %0d got %0d", e.row_span, out_beat_i.row_span);
          if (e.texture_column !== out_beat_i.texture_column)
            $error("texture_column exp %0d got %0d", e.texture_column,
                   out_beat_i.texture_column);
          if (e.texture_select !== out_beat_i.texture_select)
            $error("texture_select exp %0d got %0d", e.texture_select,
                   out_beat_i.texture_select);
        end
      end
      if (start_i && !busy_i) expected_columns.push_back(project_column(in_beat_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PLAYER_X: pos_x <= cfg_data_i;
          CFG_PLAYER_Y: pos_y <= cfg_data_i;
          CFG_TEX_WIDTH: tex_w <= cfg_data_i[12:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rcwcp_pkg::*;

  localparam int RANDOM_COLUMNS = 1750;
  localparam int DRAIN_CYCLES = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  in_beat_t in_beat_i = '0;
  logic done_o;
  out_beat_t out_beat_o;
  int fail_count;
  int pending;
  int seen;
  int sent = 0;

  always #5 clk_i = ~clk_i;

  raycast_wall_column_projection_top dut (.*);

  wall_projection_checker checker_u (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i,
    .busy_i(busy_o), .in_beat_i, .done_i(done_o), .out_beat_i(out_beat_o),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  task automatic write_reg(cfg_idx_e idx, logic [23:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_column(in_beat_t b, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      3: return 32'(signed'($urandom));
      default: return 32'(signed'($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  function automatic in_beat_t random_column(bit deep);
    in_beat_t b;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    b = raw[$bits(in_beat_t)-1:0];
    if (deep) begin
      b.ray_dir_x = pick_dir();
      b.ray_dir_y = pick_dir();
    end
    return b;
  endfunction

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_beat_t b;
    int phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    b = '0;
    b.column_index = 10'd1023;
    b.cell_x = 8'd5;
    b.cell_y = 8'd255;
    b.ray_dir_x = 32'sd65536;
    b.ray_dir_y = 32'sh0000_8000;
    send_column(b, 0);
    b.ray_dir_x = '0;
    send_column(b, 0);
    b.ray_dir_x = -32'sd65536;
    send_column(b, 0);
    b.cell_x = 8'd0;
    b.ray_dir_x = 32'sd1;
    send_column(b, 0);
    b.cell_x = 8'd255;
    b.step_x_back = 1'b1;
    send_column(b, 1);
    b.ray_dir_x = 32'sh8000_0000;
    send_column(b, 0);
    b.hit_side = 1'b1;
    b.step_y_back = 1'b1;
    b.ray_dir_y = 32'sh7FFF_FFFF;
    send_column(b, 0);
    b.ray_dir_y = 32'sd1;
    send_column(b, 0);
    b.ray_dir_y = '0;
    send_column(b, 0);
    b.cell_y = 8'd1;
    b.ray_dir_y = -32'sd70000;
    send_column(b, 2);
    settle();
    write_reg(CFG_PLAYER_X, 24'hFF_FFFF);
    write_reg(CFG_PLAYER_Y, 24'h03_8000);
    write_reg(CFG_TEX_WIDTH, 24'd4096);
    for (int i = 0; i < 8; i++) send_column(random_column(1'b1), 0);
    settle();
    write_reg(CFG_TEX_WIDTH, 24'd0);
    for (int i = 0; i < 4; i++) send_column(random_column(1'b1), 0);
    settle();
    for (phase = 0; phase < 6; phase++) begin
      write_reg(CFG_PLAYER_X, (phase == 1) ? 24'd0 : 24'($urandom));
      write_reg(CFG_PLAYER_Y, (phase == 2) ? 24'hFF_FFFF : 24'($urandom));
      case (phase)
        0: write_reg(CFG_TEX_WIDTH, 24'd1);
        1: write_reg(CFG_TEX_WIDTH, 24'd8191);
        2: write_reg(CFG_TEX_WIDTH, 24'd64);
        default: write_reg(CFG_TEX_WIDTH, 24'($urandom_range(1, 4096)));
      endcase
      for (int i = 0; i < RANDOM_COLUMNS / 6; i++)
        send_column(random_column($urandom_range(0, 9) != 0),
                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
      settle();
    end
    $display("Sent %0d column beats over nine register settings; %0d results checked.",
             sent, seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
